// ----- design/tcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer: payload
// structs, configuration register file, request kinds and control codes.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    // Glyph geometry that does not vary
    localparam int GLYPH_WIDTH   = 8;
    localparam int PAIRS_PER_ROW = GLYPH_WIDTH / 2;
    localparam int PAIR_W        = $clog2(PAIRS_PER_ROW);
    localparam int CELL_STEP     = 8;

    // Request kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PRINT = 2'd0;
    localparam t_kind KIND_LOAD  = 2'd1;
    localparam t_kind KIND_SET   = 2'd2;

    // Console control codes
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_SPACE     = 8'd32;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SCREEN_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_SCREEN_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_LINE_STRIDE   = 3'd2;
    localparam t_cfg_idx CFG_BYTES_PER_PIX = 3'd3;
    localparam t_cfg_idx CFG_FRAME_BASE    = 3'd4;
    localparam t_cfg_idx CFG_FG_COLOR      = 3'd5;
    localparam t_cfg_idx CFG_BG_COLOR      = 3'd6;

    // Configuration register file
    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [15:0] line_stride;
        logic [2:0]  bytes_per_pixel;
        logic [31:0] frame_base;
        logic [31:0] foreground_color;
        logic [31:0] background_color;
    } t_cfg;

    // Input beat
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  char_code;
        logic [3:0]  glyph_line;
        logic [7:0]  line_bits;
        logic [11:0] new_column;
        logic [11:0] new_line;
    } t_in_item;

    // Output beat: one pixel pair
    typedef struct packed {
        logic [31:0] pixel_address;
        logic [63:0] color_pair;
        logic [1:0]  pair_enable;
        logic        last;
    } t_out_item;

    // Paint request: cursor position of the cell to draw
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
    } t_paint_cmd;

endpackage

// ----- design/text_console_glyph_renderer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console renderer: pixel cursor, console controls, glyph row store
// and a painter that turns one character into pixel-pair writes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------
//  in       | sink      | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out      | source    | o_out_valid/ i_out_stall| o_out_item (t_out_item)
//  cfg      | sink      | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// A painted character runs through a setup multiply, the first glyph row read,
// then one pixel pair per cycle while the output is not stalled.
// The glyph store read port delivers one row ahead of the pair sequencer.
// Loads, cursor moves, newline and backspace at the origin start no paint.
// Reset is synchronous; the glyph store holds no reset value.
// Output stalls freeze the sequencer; input is stalled while painting.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top
    import tcgr_pkg::*;
#(
    parameter int GLYPH_HEIGHT = 16,
    parameter int GLYPH_COUNT  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cfg              r_cfg;
    logic [11:0]       r_cur_col;
    logic [11:0]       r_cur_row;
    logic [11:0]       n_cur_col;
    logic [11:0]       n_cur_row;

    logic              w_accept;
    logic              w_busy;
    logic              w_start;
    logic              w_is_bs;
    t_paint_cmd        w_cmd;
    logic [ADDR_W-1:0] w_glyph_base;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;
    logic [12:0]       w_col_t;
    logic [12:0]       w_row_t;
    logic [12:0]       w_row_s;
    logic [12:0]       w_h13;

    // Glyph index modulo the glyph count (one subtraction, exact for counts of 128 to 256)
    function automatic logic [8:0] glyph_index(input logic [7:0] code);
        logic [8:0] ext;
        ext = {1'b0, code};
        if (ext >= 9'(GLYPH_COUNT)) begin
            ext = ext - 9'(GLYPH_COUNT);
        end
        return ext;
    endfunction

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = w_busy;
    assign o_cfg_ready = 1'b1;
    assign w_h13       = 13'(GLYPH_HEIGHT);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width     <= 12'd640;
            r_cfg.screen_height    <= 12'd480;
            r_cfg.line_stride      <= 16'd2560;
            r_cfg.bytes_per_pixel  <= 3'd4;
            r_cfg.frame_base       <= 32'd0;
            r_cfg.foreground_color <= 32'h00FF_FFFF;
            r_cfg.background_color <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_cfg.screen_width     <= i_cfg_data[11:0];
                CFG_SCREEN_HEIGHT: r_cfg.screen_height    <= i_cfg_data[11:0];
                CFG_LINE_STRIDE:   r_cfg.line_stride      <= i_cfg_data[15:0];
                CFG_BYTES_PER_PIX: r_cfg.bytes_per_pixel  <= i_cfg_data[2:0];
                CFG_FRAME_BASE:    r_cfg.frame_base       <= i_cfg_data;
                CFG_FG_COLOR:      r_cfg.foreground_color <= i_cfg_data;
                CFG_BG_COLOR:      r_cfg.background_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Cursor update and paint decision
    assign w_col_t = {1'b0, r_cur_col} + 13'(CELL_STEP);
    assign w_row_t = {1'b0, r_cur_row} + w_h13;

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        w_start   = 1'b0;
        w_is_bs   = 1'b0;
        w_row_s   = {1'b0, r_cur_row};
        if (w_accept) begin
            unique case (i_in_item.kind)
                KIND_SET: begin
                    n_cur_col = i_in_item.new_column;
                    n_cur_row = i_in_item.new_line;
                end
                KIND_PRINT: begin
                    if (i_in_item.char_code == CODE_NEWLINE) begin
                        n_cur_col = '0;
                        n_cur_row = (w_row_t + w_h13 > {1'b0, r_cfg.screen_height})
                                    ? 12'd0 : w_row_t[11:0];
                    end else if (i_in_item.char_code == CODE_BACKSPACE) begin
                        if (r_cur_col != '0 || r_cur_row != '0) begin
                            w_start = 1'b1;
                            w_is_bs = 1'b1;
                            if (r_cur_col == '0) begin
                                n_cur_col = (r_cfg.screen_width >= 12'(CELL_STEP))
                                            ? r_cfg.screen_width - 12'(CELL_STEP) : 12'd0;
                                n_cur_row = (r_cur_row >= 12'(GLYPH_HEIGHT))
                                            ? r_cur_row - 12'(GLYPH_HEIGHT) : 12'd0;
                            end else begin
                                n_cur_col = (r_cur_col >= 12'(CELL_STEP))
                                            ? r_cur_col - 12'(CELL_STEP) : 12'd0;
                            end
                        end
                    end else begin
                        w_start = 1'b1;
                        // advance one cell, wrap the line, then wrap the screen
                        if (w_col_t + 13'(CELL_STEP) > {1'b0, r_cfg.screen_width}) begin
                            n_cur_col = '0;
                            w_row_s   = w_row_t;
                        end else begin
                            n_cur_col = w_col_t[11:0];
                        end
                        n_cur_row = (w_row_s + w_h13 > {1'b0, r_cfg.screen_height})
                                    ? 12'd0 : w_row_s[11:0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
        end
    end

    // Backspace paints a space at the moved cursor, print at the current one
    assign w_cmd.col    = w_is_bs ? n_cur_col : r_cur_col;
    assign w_cmd.row    = w_is_bs ? n_cur_row : r_cur_row;
    assign w_glyph_base = ADDR_W'(glyph_index(w_is_bs ? CODE_SPACE : i_in_item.char_code)
                                  * GLYPH_HEIGHT);

    // Glyph row load
    assign w_wr_en   = w_accept && (i_in_item.kind == KIND_LOAD)
                       && (32'(i_in_item.glyph_line) < GLYPH_HEIGHT);
    assign w_wr_addr = ADDR_W'(glyph_index(i_in_item.char_code) * GLYPH_HEIGHT
                               + 32'(i_in_item.glyph_line));

    tcgr_glyph_mem #(
        .DEPTH (DEPTH)
    ) u_glyph_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_in_item.line_bits),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tcgr_painter #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .ADDR_W       (ADDR_W)
    ) u_painter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_cmd        (w_cmd),
        .i_glyph_base (w_glyph_base),
        .i_cfg        (r_cfg),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_item   (o_out_item),
        .o_busy       (w_busy)
    );

    // Checks
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_busy)
        else $error("paint started while painter busy");

    a_load_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_busy && !w_rd_en)
        else $error("glyph store written during a paint");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_busy)
        else $error("painter did not take the paint request");

    a_enable_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.pair_enable[1] && !o_out_item.pair_enable[0]))
        else $error("second pixel visible without the first");

endmodule

// ----- design/tcgr_glyph_mem.sv -----
// ----------------------------------------------------------------------------
// tcgr_glyph_mem
// Glyph row store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcgr_glyph_mem #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [7:0]               o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/tcgr_painter.sv -----
// ----------------------------------------------------------------------------
// tcgr_painter
// Glyph painting sequencer: fetches glyph rows from the store one row ahead
// and, unless the output stalls, emits one pixel pair per cycle through the output register.
// ----------------------------------------------------------------------------
module tcgr_painter
    import tcgr_pkg::*;
#(
    parameter int GLYPH_HEIGHT = 16,
    parameter int ADDR_W       = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_paint_cmd        i_cmd,
    input  logic [ADDR_W-1:0] i_glyph_base,
    input  t_cfg              i_cfg,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output t_out_item         o_out_item,
    output logic              o_busy
);

    localparam int ROW_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_PAINT = 4'b1000
    } t_state;

    t_state            r_state;
    logic [11:0]       r_col;
    logic [12:0]       r_y;
    logic [27:0]       r_prod;
    logic [14:0]       r_xbase;
    logic [31:0]       r_row_addr;
    logic [12:0]       r_x;
    logic [15:0]       r_x_off;
    logic [7:0]        r_bits;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [ROW_W-1:0]  r_row_cnt;
    logic [PAIR_W-1:0] r_pair;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_adv;
    logic              w_row_end;
    logic              w_last_row;
    logic              w_y_vis;
    logic [12:0]       w_x1;

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_row_end  = (r_pair == PAIR_W'(PAIRS_PER_ROW - 1));
    assign w_last_row = (r_row_cnt == ROW_W'(GLYPH_HEIGHT - 1));
    assign w_y_vis    = r_y < {1'b0, i_cfg.screen_height};
    assign w_x1       = r_x + 13'd1;

    // Row fetch: row 0 in setup, row 1 in fetch, then one row ahead
    always_comb begin
        o_rd_en = 1'b0;
        unique case (r_state)
            ST_SETUP: o_rd_en = 1'b1;
            ST_FETCH: o_rd_en = (GLYPH_HEIGHT > 1);
            ST_PAINT: o_rd_en = w_adv && w_row_end
                                && (32'(r_row_cnt) + 2 < GLYPH_HEIGHT);
            default:  o_rd_en = 1'b0;
        endcase
    end

    assign o_rd_addr = r_rd_addr;

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE:  if (i_start) r_state <= ST_SETUP;
                ST_SETUP: r_state <= ST_FETCH;
                ST_FETCH: r_state <= ST_PAINT;
                ST_PAINT: if (w_adv && w_row_end && w_last_row) r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    // Address and pattern datapath
    always_ff @(posedge i_clk) begin
        if (o_rd_en) begin
            r_rd_addr <= r_rd_addr + ADDR_W'(1);
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_col     <= i_cmd.col;
                    r_y       <= {1'b0, i_cmd.row};
                    r_rd_addr <= i_glyph_base;
                end
            end
            ST_SETUP: begin
                r_prod  <= 28'(r_y[11:0]) * 28'(i_cfg.line_stride);
                r_xbase <= 15'(r_col) * 15'(i_cfg.bytes_per_pixel);
                r_x     <= {1'b0, r_col};
            end
            ST_FETCH: begin
                r_row_addr <= i_cfg.frame_base + 32'(r_prod);
                r_x_off    <= 16'(r_xbase);
                r_bits     <= i_rd_data;
                r_pair     <= '0;
                r_row_cnt  <= '0;
            end
            ST_PAINT: begin
                if (w_adv) begin
                    if (w_row_end) begin
                        r_pair     <= '0;
                        r_x        <= {1'b0, r_col};
                        r_x_off    <= 16'(r_xbase);
                        r_y        <= r_y + 13'd1;
                        r_row_addr <= r_row_addr + 32'(i_cfg.line_stride);
                        r_row_cnt  <= r_row_cnt + ROW_W'(1);
                        r_bits     <= i_rd_data;
                    end else begin
                        r_pair  <= r_pair + PAIR_W'(1);
                        r_x     <= r_x + 13'd2;
                        r_x_off <= r_x_off + {12'd0, i_cfg.bytes_per_pixel, 1'b0};
                        r_bits  <= {r_bits[5:0], 2'b00};
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_PAINT && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PAINT && w_adv) begin
            r_out_item.pixel_address <= r_row_addr + 32'(r_x_off);
            r_out_item.color_pair    <= {
                (r_bits[6] ? i_cfg.foreground_color : i_cfg.background_color),
                (r_bits[7] ? i_cfg.foreground_color : i_cfg.background_color)};
            r_out_item.pair_enable   <= {
                w_y_vis && (w_x1 < {1'b0, i_cfg.screen_width}),
                w_y_vis && (r_x < {1'b0, i_cfg.screen_width})};
            r_out_item.last          <= w_row_end && w_last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_busy      = (r_state != ST_IDLE);

endmodule
